@@ rtl/wvnh_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, hash link and sine table entry function for the warped noise block.
package wvnh_pkg;

	// Default configuration of the block.
	localparam int WARP_ROUNDS_DEF     = 7;
	localparam int CELL_SHIFT_DEF      = 7;
	localparam int FRAC_BITS_DEF       = 8;
	localparam int SINE_TABLE_BITS_DEF = 12;

	// Angle constants in Q4.28.
	localparam logic [63:0] Q28_ONE     = 64'd268435456;
	localparam logic [63:0] Q28_TWO_PI  = 64'd1686629713;
	localparam logic [63:0] Q28_PI      = 64'd843314857;
	localparam logic [63:0] Q28_HALF_PI = 64'd421657428;

	// Blend weights 0.7 and 0.3 in Q0.16.
	localparam logic [15:0] BLEND_OLD = 16'd45875;
	localparam logic [15:0] BLEND_NEW = 16'd19661;

	// One link of the corner hash: wrapped add, sign extension, xorshift 13/7/17.
	function automatic logic [31:0] hash_link(input logic [31:0] acc, input logic [31:0] v);
		logic [31:0] t;
		logic [63:0] u;
		t = acc + v;
		u = {{32{t[31]}}, t};
		u = u ^ (u << 13);
		u = u ^ (u >> 7);
		u = u ^ (u << 17);
		return u[31:0];
	endfunction

	// Sine of a nonnegative Q4.28 angle as {negative flag, magnitude in Q1.16}.
	// Only evaluated with constant arguments to build the lookup tables.
	function automatic logic [17:0] sine_entry(input logic [63:0] ang);
		logic [63:0] a;
		logic [63:0] x2;
		logic [63:0] h;
		logic [63:0] s;
		logic [63:0] r;
		logic        neg;
		a = ang % Q28_TWO_PI;
		neg = 1'b0;
		if (a >= Q28_PI) begin
			a = a - Q28_PI;
			neg = 1'b1;
		end
		if (a > Q28_HALF_PI) begin
			a = (a <= Q28_PI) ? (Q28_PI - a) : 64'd0;
		end
		x2 = (a * a) >> 28;
		h = Q28_ONE - x2 / 110;
		h = Q28_ONE - ((x2 * h) >> 28) / 72;
		h = Q28_ONE - ((x2 * h) >> 28) / 42;
		h = Q28_ONE - ((x2 * h) >> 28) / 20;
		h = Q28_ONE - ((x2 * h) >> 28) / 6;
		s = (a * h) >> 28;
		r = (s + 64'd2048) >> 12;
		if (r > 64'd65536) begin
			r = 64'd65536;
		end
		if (r == 64'd0) begin
			neg = 1'b0;
		end
		return {neg, r[16:0]};
	endfunction

endpackage

@@ rtl/wvnh_sample.sv @@
`timescale 1ns / 1ps
// Six-stage bilinear value noise sampler with pass-through of point and blend value.
module wvnh_sample #(
	parameter int FRAC_BITS  = wvnh_pkg::FRAC_BITS_DEF,
	parameter int CELL_SHIFT = wvnh_pkg::CELL_SHIFT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           hash_seed,
	input  logic                  in_valid,
	input  logic [32+FRAC_BITS-1:0] in_cx,
	input  logic [32+FRAC_BITS-1:0] in_cz,
	input  logic [15:0]           in_o,
	output logic                  out_valid,
	output logic [32+FRAC_BITS-1:0] out_cx,
	output logic [32+FRAC_BITS-1:0] out_cz,
	output logic [15:0]           out_o,
	output logic [15:0]           out_smp
);
	import wvnh_pkg::*;

	localparam int CW     = 32 + FRAC_BITS;
	localparam int WB     = FRAC_BITS + CELL_SHIFT;
	localparam int STAGES = 6;

	// Cell corners and weights of the incoming point.
	logic [31:0]      x1, x2, z1, z2;
	logic [WB+15:0]   offx_ext, offz_ext;
	logic [15:0]      wx2, wz2;

	assign x1 = 32'($signed(in_cx[CW-1:WB]));
	assign z1 = 32'($signed(in_cz[CW-1:WB]));
	assign x2 = x1 + 32'd1;
	assign z2 = z1 + 32'd1;
	assign offx_ext = {in_cx[WB-1:0], 16'd0};
	assign offz_ext = {in_cz[WB-1:0], 16'd0};
	assign wx2 = offx_ext[WB+15:WB];
	assign wz2 = offz_ext[WB+15:WB];

	// Pipeline registers of the sampling path.
	logic [31:0] hx1_s1, hx2_s1, z1_s1, z2_s1;
	logic [16:0] wx1_s1, wx2_s1, wz1_s1, wz2_s1;
	logic [31:0] hx1_s2, hx2_s2, z1_s2, z2_s2;
	logic [16:0] wx1_s2, wx2_s2, wz1_s2, wz2_s2;
	logic [7:0]  cv_s3 [4];
	logic [16:0] wx1_s3, wx2_s3, wz1_s3, wz2_s3;
	logic [24:0] p_s4 [4];
	logic [16:0] wz1_s4, wz2_s4;
	logic [41:0] q_s5 [4];
	logic [43:0] sum;

	// Side band that rides along the six stages.
	logic           vld_q [STAGES];
	logic [CW-1:0]  pcx_q [STAGES];
	logic [CW-1:0]  pcz_q [STAGES];
	logic [15:0]    po_q  [STAGES];

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < STAGES; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Point and blend value carried with the item.
	always_ff @(posedge clk) begin
		pcx_q[0] <= in_cx;
		pcz_q[0] <= in_cz;
		po_q[0]  <= in_o;
		for (int k = 1; k < STAGES; k++) begin
			pcx_q[k] <= pcx_q[k-1];
			pcz_q[k] <= pcz_q[k-1];
			po_q[k]  <= po_q[k-1];
		end
	end

	// Stage 1: first hash link on the cell x index, weights.
	always_ff @(posedge clk) begin
		hx1_s1 <= hash_link(32'd0, x1);
		hx2_s1 <= hash_link(32'd0, x2);
		z1_s1  <= z1;
		z2_s1  <= z2;
		wx2_s1 <= {1'b0, wx2};
		wz2_s1 <= {1'b0, wz2};
		wx1_s1 <= 17'h10000 - {1'b0, wx2};
		wz1_s1 <= 17'h10000 - {1'b0, wz2};
	end

	// Stage 2: seed link.
	always_ff @(posedge clk) begin
		hx1_s2 <= hash_link(hx1_s1, hash_seed);
		hx2_s2 <= hash_link(hx2_s1, hash_seed);
		z1_s2  <= z1_s1;
		z2_s2  <= z2_s1;
		wx1_s2 <= wx1_s1;
		wx2_s2 <= wx2_s1;
		wz1_s2 <= wz1_s1;
		wz2_s2 <= wz2_s1;
	end

	// Stage 3: last link on the cell z index gives the four corner bytes.
	always_ff @(posedge clk) begin
		cv_s3[0] <= 8'(hash_link(hx1_s2, z1_s2));
		cv_s3[1] <= 8'(hash_link(hx2_s2, z1_s2));
		cv_s3[2] <= 8'(hash_link(hx1_s2, z2_s2));
		cv_s3[3] <= 8'(hash_link(hx2_s2, z2_s2));
		wx1_s3 <= wx1_s2;
		wx2_s3 <= wx2_s2;
		wz1_s3 <= wz1_s2;
		wz2_s3 <= wz2_s2;
	end

	// Stage 4: corner times x weight.
	always_ff @(posedge clk) begin
		p_s4[0] <= 25'(cv_s3[0]) * 25'(wx1_s3);
		p_s4[1] <= 25'(cv_s3[1]) * 25'(wx2_s3);
		p_s4[2] <= 25'(cv_s3[2]) * 25'(wx1_s3);
		p_s4[3] <= 25'(cv_s3[3]) * 25'(wx2_s3);
		wz1_s4  <= wz1_s3;
		wz2_s4  <= wz2_s3;
	end

	// Stage 5: times z weight.
	always_ff @(posedge clk) begin
		q_s5[0] <= 42'(p_s4[0]) * 42'(wz1_s4);
		q_s5[1] <= 42'(p_s4[1]) * 42'(wz1_s4);
		q_s5[2] <= 42'(p_s4[2]) * 42'(wz2_s4);
		q_s5[3] <= 42'(p_s4[3]) * 42'(wz2_s4);
	end

	// Stage 6: sum of the four terms, scaled to Q8.8.
	assign sum = 44'(q_s5[0]) + 44'(q_s5[1]) + 44'(q_s5[2]) + 44'(q_s5[3]);

	always_ff @(posedge clk) begin
		out_smp <= sum[39:24];
	end

	assign out_valid = vld_q[STAGES-1];
	assign out_cx    = pcx_q[STAGES-1];
	assign out_cz    = pcz_q[STAGES-1];
	assign out_o     = po_q[STAGES-1];

endmodule

@@ rtl/warped_value_noise_height.sv @@
`timescale 1ns / 1ps
// Top level of the domain-warped value noise height pipeline.
//
//  Channel   Signals                          Handshake
//  input     start, busy, x_coord, z_coord    taken when start && !busy
//  config    cfg_valid, cfg_ready, hash_seed  written when cfg_valid && cfg_ready
//  result    done, height                     one-cycle strobe on done
//
// A new point can enter every cycle; busy stays low and cfg_ready stays high.
// The path is an input stage and one six-stage sampler, then per round a
// table read, a displacement, a sampler and a blend.
// Reset clears all valid bits; the seed register returns to zero.
// The result side has no back pressure, so nothing in the pipe ever stalls.
module warped_value_noise_height #(
	parameter int WARP_ROUNDS     = wvnh_pkg::WARP_ROUNDS_DEF,
	parameter int CELL_SHIFT      = wvnh_pkg::CELL_SHIFT_DEF,
	parameter int FRAC_BITS       = wvnh_pkg::FRAC_BITS_DEF,
	parameter int SINE_TABLE_BITS = wvnh_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_coord,
	input  logic [31:0] z_coord,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] hash_seed,
	output logic        done,
	output logic [7:0]  height
);
	import wvnh_pkg::*;

	localparam int CW        = 32 + FRAC_BITS;
	localparam int STB       = SINE_TABLE_BITS;
	localparam int TBL_DEPTH = 1 << STB;
	localparam int DW        = FRAC_BITS + 4;
	localparam int SMP_LAT   = 6;
	localparam int LAT       = 1 + SMP_LAT + 9 * WARP_ROUNDS;

	// Seed register.
	logic [31:0] seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= hash_seed;
		end
	end

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Sine and cosine tables, {negative, magnitude Q1.16}, built at elaboration.
	logic [17:0] rom_sin [TBL_DEPTH];
	logic [17:0] rom_cos [TBL_DEPTH];

	for (genvar i = 0; i < TBL_DEPTH; i++) begin : g_rom
		assign rom_sin[i] = sine_entry(64'(i) << (32 - STB));
		assign rom_cos[i] = sine_entry((64'(i) << (32 - STB)) + Q28_HALF_PI);
	end

	// Input stage: scale the point to the fixed-point coordinate format.
	logic          in_vld_s1;
	logic [CW-1:0] in_cx_s1, in_cz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else begin
			in_vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		in_cx_s1 <= {x_coord, FRAC_BITS'(0)};
		in_cz_s1 <= {z_coord, FRAC_BITS'(0)};
	end

	// Per-round state at the boundary between rounds.
	logic          r_valid [WARP_ROUNDS+1];
	logic [CW-1:0] r_cx    [WARP_ROUNDS+1];
	logic [CW-1:0] r_cz    [WARP_ROUNDS+1];
	logic [15:0]   r_o     [WARP_ROUNDS+1];
	logic [15:0]   init_o_unused;

	// Unwarped first sample; its value becomes the starting blend value.
	wvnh_sample #(
		.FRAC_BITS  (FRAC_BITS),
		.CELL_SHIFT (CELL_SHIFT)
	) u_sample0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.hash_seed (seed_q),
		.in_valid  (in_vld_s1),
		.in_cx     (in_cx_s1),
		.in_cz     (in_cz_s1),
		.in_o      (16'd0),
		.out_valid (r_valid[0]),
		.out_cx    (r_cx[0]),
		.out_cz    (r_cz[0]),
		.out_o     (init_o_unused),
		.out_smp   (r_o[0])
	);

	for (genvar r = 0; r < WARP_ROUNDS; r++) begin : g_round
		logic          vld_a_s1, vld_b_s2, vld_c_s3;
		logic [17:0]   sn_s1, cs_s1;
		logic [CW-1:0] cx_s1, cz_s1, cx_s2, cz_s2;
		logic [15:0]   o_s1, o_s2;
		logic [STB-1:0] idx;
		logic [DW+15:0] shx, shz;
		logic [DW-1:0]  dx, dz;
		logic           smp_vld;
		logic [CW-1:0]  smp_cx, smp_cz;
		logic [15:0]    smp_o, smp_new;
		logic [31:0]    blend;

		// Table read indexed by the top bits of the blend value.
		assign idx = r_o[r][15 -: STB];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a_s1 <= 1'b0;
				vld_b_s2 <= 1'b0;
				vld_c_s3 <= 1'b0;
			end else begin
				vld_a_s1 <= r_valid[r];
				vld_b_s2 <= vld_a_s1;
				vld_c_s3 <= smp_vld;
			end
		end

		always_ff @(posedge clk) begin
			sn_s1 <= rom_sin[idx];
			cs_s1 <= rom_cos[idx];
			cx_s1 <= r_cx[r];
			cz_s1 <= r_cz[r];
			o_s1  <= r_o[r];
		end

		// Displacement of 8 units scaled by the table magnitude, then wrap-around add.
		assign shx = {sn_s1[16:0], (FRAC_BITS + 3)'(0)};
		assign shz = {cs_s1[16:0], (FRAC_BITS + 3)'(0)};
		assign dx  = shx[DW+15:16];
		assign dz  = shz[DW+15:16];

		always_ff @(posedge clk) begin
			cx_s2 <= sn_s1[17] ? (cx_s1 - CW'(dx)) : (cx_s1 + CW'(dx));
			cz_s2 <= cs_s1[17] ? (cz_s1 - CW'(dz)) : (cz_s1 + CW'(dz));
			o_s2  <= o_s1;
		end

		wvnh_sample #(
			.FRAC_BITS  (FRAC_BITS),
			.CELL_SHIFT (CELL_SHIFT)
		) u_sample (
			.clk       (clk),
			.arst_n    (arst_n),
			.hash_seed (seed_q),
			.in_valid  (vld_b_s2),
			.in_cx     (cx_s2),
			.in_cz     (cz_s2),
			.in_o      (o_s2),
			.out_valid (smp_vld),
			.out_cx    (smp_cx),
			.out_cz    (smp_cz),
			.out_o     (smp_o),
			.out_smp   (smp_new)
		);

		// Blend of the old value and the new sample.
		assign blend = 32'(smp_o) * 32'(BLEND_OLD) + 32'(smp_new) * 32'(BLEND_NEW);

		always_ff @(posedge clk) begin
			r_cx[r+1] <= smp_cx;
			r_cz[r+1] <= smp_cz;
			r_o[r+1]  <= blend[31:16];
		end

		assign r_valid[r+1] = vld_c_s3;
	end

	assign done   = r_valid[WARP_ROUNDS];
	assign height = r_o[WARP_ROUNDS][15:8];

	// Every result traces back to an earlier request taken at the input.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	// Every first sample out of its sampler traces back to a request taken through the input stage.
	a_first_sample: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid[0] |-> $past(start && !busy, SMP_LAT + 1))
		else $error("first sample out of step with its request");

	// A blend of samples never exceeds the largest corner value.
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (r_o[WARP_ROUNDS] <= 16'hFF00))
		else $error("blend value out of range");

endmodule
